/* hdl/tick_task_scheduler_defines.svh */
// Assertion macros shared by the tick task scheduler RTL.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef TICK_TASK_SCHEDULER_DEFINES_SVH
`define TICK_TASK_SCHEDULER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define TTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/tts_pkg.sv */
// Shared types and constants for the tick task scheduler.
// No dependencies; used by tts_result_reg and tick_task_scheduler.
`default_nettype none

package tts_pkg;

    // Table geometry.
    localparam int NUM_SLOTS   = 16;
    localparam int MAX_RESULTS = 16;
    localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // Field widths.
    localparam int HANDLE_W = 8;
    localparam int TIME_W   = 16;
    localparam int ID_W     = 16;
    localparam int STATUS_W = 3;

    // Request codes.
    typedef enum logic [1:0] {
        REQ_ADD      = 2'd0,
        REQ_TICK     = 2'd1,
        REQ_DISPATCH = 2'd2,
        REQ_DELETE   = 2'd3
    } t_req;

    // Status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_FULL        = 3'd1,
        ST_NOT_FOUND   = 3'd2,
        ST_NONE_READY  = 3'd3,
        ST_ZERO_HANDLE = 3'd4
    } t_status;

    // One task slot as stored in the slot memory.
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [TIME_W-1:0]   delay;
        logic [TIME_W-1:0]   period;
        logic                ready;
        logic [ID_W-1:0]     id;
    } t_slot;

    // One result word.
    typedef struct packed {
        t_status             status;
        logic [ID_W-1:0]     id;
        logic [HANDLE_W-1:0] handle;
        logic                last;
    } t_result;

endpackage

`default_nettype wire

/* hdl/tts_result_reg.sv */
// Output register stage for result words of the tick task scheduler.
// Depends on tts_pkg for the result word type.
`default_nettype none

module tts_result_reg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire tts_pkg::t_result i_word,
    input  wire logic             i_stall,
    output logic                  o_free,
    output logic                  o_valid,
    output tts_pkg::t_result      o_word
);
    import tts_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_word;

    // The stage can take a word when it is empty or its word leaves now.
    assign o_free  = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    // Valid flag: drops when the word is taken, rises on a push.
    always_comb begin
        n_valid = r_valid;
        if (r_valid && !i_stall) begin
            n_valid = 1'b0;
        end
        if (i_push) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_word <= i_word;
        end
    end

endmodule

`default_nettype wire

/* hdl/tick_task_scheduler.sv */
// Tick task scheduler: a table of task slots in one synchronous memory, served by
// a slot-by-slot sequencer. Requests add a task, tick all timers, dispatch ready
// tasks or delete a task by id. Each request walks the slot memory through its
// single read port, one slot per cycle while the output stage can take a word; a
// tick or dispatch visits every slot, an add or delete stops at the slot it hits,
// and an add with a zero handle or a delete of id 0 skips the walk. The walk
// pauses while the output is stalled with a word waiting. A new request is taken
// only while the sequencer is idle; the last result word may still wait in the
// output register while the next request is accepted. Reset frees all slots at
// once through per-slot occupied flags; no clearing pass.
`default_nettype none
`include "tick_task_scheduler_defines.svh"

module tick_task_scheduler (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Request channel.
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [1:0]                    i_req_type,
    input  wire logic [tts_pkg::HANDLE_W-1:0]  i_task_handle,
    input  wire logic [tts_pkg::TIME_W-1:0]    i_start_delay,
    input  wire logic [tts_pkg::TIME_W-1:0]    i_repeat_period,
    input  wire logic [tts_pkg::ID_W-1:0]      i_target_id,
    // Result channel.
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [tts_pkg::STATUS_W-1:0]       o_status,
    output logic [tts_pkg::ID_W-1:0]           o_result_id,
    output logic [tts_pkg::HANDLE_W-1:0]       o_run_handle,
    output logic                               o_last
);
    import tts_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    // Control state.
    t_state                r_state,    n_state;
    logic [SLOT_W-1:0]     r_slot,     n_slot;
    logic [NUM_SLOTS-1:0]  r_occ,      n_occ;
    logic [ID_W-1:0]       r_id_ctr,   n_id_ctr;
    logic                  r_pend_vld, n_pend_vld;
    logic [CNT_W-1:0]      r_cnt,      n_cnt;

    // Request and result payload.
    t_req                  r_req;
    logic [HANDLE_W-1:0]   r_handle;
    logic [TIME_W-1:0]     r_delay;
    logic [TIME_W-1:0]     r_period;
    logic [ID_W-1:0]       r_target;
    t_status               r_fin_status, n_fin_status;
    logic [ID_W-1:0]       r_fin_id,     n_fin_id;
    logic [ID_W-1:0]       r_pend_id,    n_pend_id;
    logic [HANDLE_W-1:0]   r_pend_handle, n_pend_handle;

    // Slot memory and its ports.
    t_slot                 r_mem [NUM_SLOTS];
    t_slot                 r_rd;
    logic                  rd_en;
    logic [SLOT_W-1:0]     rd_addr;
    logic                  wr_en;
    logic [SLOT_W-1:0]     wr_addr;
    t_slot                 wr_data;

    // Output stage handshake.
    logic                  out_free;
    logic                  push;
    t_result               push_word;
    t_result               out_word;

    // Helpers.
    logic                  accept;
    logic [ID_W-1:0]       id_inc;
    logic [ID_W-1:0]       new_id;
    logic                  slot_occ;
    logic                  last_slot;
    logic                  done;

    assign accept    = i_valid && !o_stall;
    assign o_stall   = (r_state != S_IDLE);
    assign id_inc    = r_id_ctr + ID_W'(1);
    assign new_id    = (id_inc == '0) ? ID_W'(1) : id_inc;
    assign slot_occ  = r_occ[r_slot];
    assign last_slot = (r_slot == SLOT_W'(NUM_SLOTS - 1));

    // Sequencer: read one slot per cycle while the output stage is free, modify it and write it back.
    always_comb begin
        n_state       = r_state;
        n_slot        = r_slot;
        n_occ         = r_occ;
        n_id_ctr      = r_id_ctr;
        n_pend_vld    = r_pend_vld;
        n_cnt         = r_cnt;
        n_fin_status  = r_fin_status;
        n_fin_id      = r_fin_id;
        n_pend_id     = r_pend_id;
        n_pend_handle = r_pend_handle;
        rd_en         = 1'b0;
        rd_addr       = r_slot;
        wr_en         = 1'b0;
        wr_addr       = r_slot;
        wr_data       = r_rd;
        push          = 1'b0;
        push_word     = '0;
        done          = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_pend_vld = 1'b0;
                    n_cnt      = '0;
                    n_slot     = '0;
                    n_fin_id   = '0;
                    // Answer given when the walk finds nothing.
                    case (t_req'(i_req_type))
                        REQ_ADD:      n_fin_status = ST_FULL;
                        REQ_TICK:     n_fin_status = ST_OK;
                        REQ_DISPATCH: n_fin_status = ST_NONE_READY;
                        default:      n_fin_status = ST_NOT_FOUND;
                    endcase
                    if (t_req'(i_req_type) == REQ_ADD && i_task_handle == '0) begin
                        n_fin_status = ST_ZERO_HANDLE;
                        n_state      = S_FIN;
                    end else if (t_req'(i_req_type) == REQ_DELETE && i_target_id == '0) begin
                        n_state = S_FIN;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = '0;
                        n_state = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                // r_rd holds slot r_slot; it stays put while the output is blocked.
                if (out_free) begin
                    case (r_req)
                        REQ_ADD: begin
                            if (!slot_occ) begin
                                wr_en          = 1'b1;
                                wr_data.handle = r_handle;
                                wr_data.delay  = r_delay;
                                wr_data.period = r_period;
                                wr_data.ready  = 1'b0;
                                wr_data.id     = new_id;
                                n_occ[r_slot]  = 1'b1;
                                n_id_ctr       = new_id;
                                n_fin_status   = ST_OK;
                                n_fin_id       = new_id;
                                done           = 1'b1;
                            end
                        end
                        REQ_TICK: begin
                            if (slot_occ) begin
                                wr_en = 1'b1;
                                if (r_rd.delay != '0) begin
                                    wr_data.delay = r_rd.delay - TIME_W'(1);
                                end else begin
                                    wr_data.ready = 1'b1;
                                    if (r_rd.period != '0) begin
                                        wr_data.delay = r_rd.period;
                                    end
                                end
                            end
                        end
                        REQ_DISPATCH: begin
                            if (slot_occ && r_rd.ready && r_cnt < CNT_W'(MAX_RESULTS)) begin
                                // The held word is not the last one: send it now.
                                if (r_pend_vld) begin
                                    push             = 1'b1;
                                    push_word.status = ST_OK;
                                    push_word.id     = r_pend_id;
                                    push_word.handle = r_pend_handle;
                                    push_word.last   = 1'b0;
                                end
                                n_pend_vld    = 1'b1;
                                n_pend_id     = r_rd.id;
                                n_pend_handle = r_rd.handle;
                                n_cnt         = r_cnt + CNT_W'(1);
                                wr_en         = 1'b1;
                                wr_data.ready = 1'b0;
                                if (r_rd.period == '0) begin
                                    n_occ[r_slot] = 1'b0;
                                end
                            end
                        end
                        default: begin
                            if (slot_occ && r_rd.id == r_target) begin
                                n_occ[r_slot] = 1'b0;
                                n_fin_status  = ST_OK;
                                done          = 1'b1;
                            end
                        end
                    endcase

                    if (done || last_slot) begin
                        n_state = S_FIN;
                    end else begin
                        n_slot  = r_slot + SLOT_W'(1);
                        rd_en   = 1'b1;
                        rd_addr = r_slot + SLOT_W'(1);
                    end
                end
            end

            S_FIN: begin
                // Final word: the held dispatch word, or the request's status.
                if (out_free) begin
                    push           = 1'b1;
                    push_word.last = 1'b1;
                    if (r_pend_vld) begin
                        push_word.status = ST_OK;
                        push_word.id     = r_pend_id;
                        push_word.handle = r_pend_handle;
                    end else begin
                        push_word.status = r_fin_status;
                        push_word.id     = r_fin_id;
                        push_word.handle = '0;
                    end
                    n_pend_vld = 1'b0;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_slot     <= '0;
            r_occ      <= '0;
            r_id_ctr   <= '0;
            r_pend_vld <= 1'b0;
            r_cnt      <= '0;
        end else begin
            r_state    <= n_state;
            r_slot     <= n_slot;
            r_occ      <= n_occ;
            r_id_ctr   <= n_id_ctr;
            r_pend_vld <= n_pend_vld;
            r_cnt      <= n_cnt;
        end
    end

    // Request capture and result payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req    <= t_req'(i_req_type);
            r_handle <= i_task_handle;
            r_delay  <= i_start_delay;
            r_period <= i_repeat_period;
            r_target <= i_target_id;
        end
        r_fin_status  <= n_fin_status;
        r_fin_id      <= n_fin_id;
        r_pend_id     <= n_pend_id;
        r_pend_handle <= n_pend_handle;
    end

    // Slot memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    // Output register stage.
    tts_result_reg u_result_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (push_word),
        .i_stall (i_stall),
        .o_free  (out_free),
        .o_valid (o_valid),
        .o_word  (out_word)
    );

    assign o_status     = out_word.status;
    assign o_result_id  = out_word.id;
    assign o_run_handle = out_word.handle;
    assign o_last       = out_word.last;

    // A slot is never read in the cycle it is written.
    `TTS_ASSERT_NOW(a_no_rw_collision, rd_en && wr_en, rd_addr != wr_addr,
        "slot memory read and write hit the same entry")
    // A word is only pushed when the output stage can take it.
    `TTS_ASSERT_NOW(a_push_when_free, push, out_free,
        "result word pushed into a full output stage")
    // A held dispatch word only exists during a dispatch.
    `TTS_ASSERT_NOW(a_pend_dispatch, r_pend_vld && r_state != S_IDLE,
        r_req == REQ_DISPATCH, "held dispatch word outside a dispatch")
    // A successful add never hands out id zero.
    `TTS_ASSERT_NOW(a_id_nonzero,
        r_state == S_FIN && r_req == REQ_ADD && r_fin_status == ST_OK,
        r_fin_id != '0, "add returned id zero")
    // An accepted request always leaves the idle state.
    `TTS_ASSERT_NEXT(a_accept_busy, accept, r_state != S_IDLE,
        "accepted request did not start")

endmodule

`default_nettype wire
